// File: src/ffp_pkg.sv
package ffp_pkg;

   localparam int BLOCK_W       = 128;
   localparam int KEY_W         = 256;
   localparam int MAX_OUT_BYTES = 64;
   localparam int AES_ROUNDS    = 14;
   localparam int BLOCK_BYTES   = 16;

   localparam logic [7:0] SBOX [256] = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
   };

   function automatic logic [7:0] xtime(input logic [7:0] v);
      return {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
   endfunction

   function automatic logic [31:0] sub_word(input logic [31:0] w);
      return {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
   endfunction

   // One AES round without the key add. Byte k of the block sits at bits
   // [127-8k -: 8]; the final round skips MixColumns.
   function automatic logic [127:0] aes_round(input logic [127:0] s, input logic last);
      logic [7:0] sb [16];
      logic [7:0] t  [16];
      logic [7:0] a0, a1, a2, a3, all;
      logic [127:0] res;
      for (int k = 0; k < 16; k++) begin
         sb[k] = s[127-8*k -: 8];
      end
      for (int c = 0; c < 4; c++) begin
         for (int r = 0; r < 4; r++) begin
            t[r+4*c] = SBOX[sb[r + 4*((c+r) & 3)]];
         end
      end
      for (int c = 0; c < 4; c++) begin
         a0  = t[4*c];
         a1  = t[4*c+1];
         a2  = t[4*c+2];
         a3  = t[4*c+3];
         all = a0 ^ a1 ^ a2 ^ a3;
         if (last) begin
            res[127-32*c -: 32] = {a0, a1, a2, a3};
         end else begin
            res[127-32*c -: 32] = {a0 ^ all ^ xtime(a0 ^ a1), a1 ^ all ^ xtime(a1 ^ a2),
                                   a2 ^ all ^ xtime(a2 ^ a3), a3 ^ all ^ xtime(a3 ^ a0)};
         end
      end
      return res;
   endfunction

endpackage

// File: src/ff1_prf_aes256_cbc_mac.sv
// FF1 pseudorandom function: AES-256 CBC-MAC with counter extension.
// Message blocks arrive as words on the req_ stream; req_tlast marks the
// final block of a message, whose out_len field gives the requested number
// of output bytes. The key is written as four 64-bit registers over the
// csr_ port at byte addresses 0, 8, 16 and 24; the user must write it only
// while the block is idle, which the block itself does not enforce. Each
// accepted word costs one AES-256 encryption on a single shared round unit:
// a load, fourteen rounds and a step to take the result, and req_tready
// stays low meanwhile. On the final block the chaining value is sent as the
// first rsp_ word; every further 16-byte word is one more encryption of the
// chaining value with a counter. rsp_tlast marks the last word of the run
// and valid_bytes gives its leading bytes that count.
// If the receiver stalls, the result word holds on rsp_ and the block waits.
// Reset clears the chain, the key registers and most control state; len, rtake and rlast are not reset.
module ff1_prf_aes256_cbc_mac #(
   parameter int MAX_OUT_BYTES = ffp_pkg::MAX_OUT_BYTES
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   input  logic [135:0]  req_tdata,  // block_hi, block_lo, out_len, zero fill
   input  logic          req_tlast,  // last_block
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   output logic [135:0]  rsp_tdata,  // out_hi, out_lo, valid_bytes, zero fill
   output logic          rsp_tlast,  // final_result
   input  logic          csr_psel,
   input  logic          csr_penable,
   input  logic          csr_pwrite,
   input  logic [4:0]    csr_paddr,
   input  logic [63:0]   csr_pwdata,
   output logic [63:0]   csr_prdata,
   output logic          csr_pready
);
   import ffp_pkg::*;

   localparam int REM_W = $clog2(MAX_OUT_BYTES + 1);
   localparam int CTR_W = $clog2(MAX_OUT_BYTES / BLOCK_BYTES + 1);
   localparam int CMP_W = (REM_W > 7) ? REM_W : 7;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_RUN  = 2'd1;
   localparam logic [1:0] ST_OUT  = 2'd2;

   localparam logic [1:0] REG_KEY0 = 2'd0;
   localparam logic [1:0] REG_KEY1 = 2'd1;
   localparam logic [1:0] REG_KEY2 = 2'd2;
   localparam logic [1:0] REG_KEY3 = 2'd3;

   logic [63:0]        key_ff [4];
   logic [1:0]         st_ff, st_in;
   logic [BLOCK_W-1:0] chain_ff, chain_in;
   logic               last_ff, last_in;
   logic               ext_ff, ext_in;
   logic [REM_W-1:0]   len_ff, len_in;
   logic [REM_W-1:0]   rem_ff, rem_in;
   logic [CTR_W-1:0]   ctr_ff, ctr_in;
   logic               rvalid_ff, rvalid_in;
   logic [BLOCK_W-1:0] rdata_ff, rdata_in;
   logic [4:0]         rtake_ff, rtake_in;
   logic               rlast_ff, rlast_in;

   logic               core_start, core_done;
   logic [BLOCK_W-1:0] core_din, core_dout;
   logic               req_fire, rsp_fire, csr_wr;
   logic [CMP_W-1:0]   len_ext;
   logic [REM_W-1:0]   emit_rem, rem_after;
   logic [4:0]         take;

   // Key register file.
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;
   assign csr_prdata = key_ff[csr_paddr[4:3]];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 4; i++) begin
            key_ff[i] <= 64'h0;
         end
      end else if (csr_wr) begin
         unique case (csr_paddr[4:3])
            REG_KEY0: key_ff[0] <= csr_pwdata;
            REG_KEY1: key_ff[1] <= csr_pwdata;
            REG_KEY2: key_ff[2] <= csr_pwdata;
            REG_KEY3: key_ff[3] <= csr_pwdata;
            default:  key_ff[0] <= key_ff[0];
         endcase
      end
   end

   ffp_aes_core u_core (
      .clock (clock),
      .reset (reset),
      .start (core_start),
      .key   ({key_ff[0], key_ff[1], key_ff[2], key_ff[3]}),
      .din   (core_din),
      .done  (core_done),
      .dout  (core_dout)
   );

   assign req_tready = (st_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign rsp_fire   = rvalid_ff && rsp_tready;

   // Output length saturates at the configured maximum.
   assign len_ext = CMP_W'(req_tdata[134:128]);

   // Bytes still owed before the word being emitted: on the first word of a
   // run that is the requested length, afterwards the running count.
   assign emit_rem  = ext_ff ? rem_ff : len_ff;
   assign take      = (emit_rem > REM_W'(BLOCK_BYTES)) ? 5'(BLOCK_BYTES) : 5'(emit_rem);
   assign rem_after = emit_rem - REM_W'(take);

   always_comb begin
      st_in      = st_ff;
      chain_in   = chain_ff;
      last_in    = last_ff;
      ext_in     = ext_ff;
      len_in     = len_ff;
      rem_in     = rem_ff;
      ctr_in     = ctr_ff;
      rvalid_in  = rvalid_ff;
      rdata_in   = rdata_ff;
      rtake_in   = rtake_ff;
      rlast_in   = rlast_ff;
      core_start = 1'b0;
      // block_hi sits in the low half of the word, block_lo above it.
      core_din   = chain_ff ^ {req_tdata[63:0], req_tdata[127:64]};
      unique case (st_ff)
         ST_IDLE: begin
            if (req_fire) begin
               core_start = 1'b1;
               last_in    = req_tlast;
               len_in     = (len_ext > CMP_W'(MAX_OUT_BYTES)) ?
                            REM_W'(MAX_OUT_BYTES) : REM_W'(len_ext);
               st_in      = ST_RUN;
            end
         end
         ST_RUN: begin
            if (core_done) begin
               if (ext_ff) begin
                  rvalid_in = 1'b1;
                  rdata_in  = core_dout;
                  rtake_in  = take;
                  rlast_in  = (rem_after == '0);
                  rem_in    = rem_after;
                  ctr_in    = ctr_ff + CTR_W'(1);
                  st_in     = ST_OUT;
               end else begin
                  chain_in = core_dout;
                  if (!last_ff) begin
                     st_in = ST_IDLE;
                  end else if (len_ff == '0) begin
                     chain_in = '0;
                     st_in    = ST_IDLE;
                  end else begin
                     rvalid_in = 1'b1;
                     rdata_in  = core_dout;
                     rtake_in  = take;
                     rlast_in  = (rem_after == '0);
                     rem_in    = rem_after;
                     st_in     = ST_OUT;
                  end
               end
            end
         end
         ST_OUT: begin
            core_din = chain_ff ^ {96'h0, 32'(ctr_ff)};
            if (rsp_fire) begin
               rvalid_in = 1'b0;
               if (rem_ff == '0) begin
                  chain_in = '0;
                  ctr_in   = CTR_W'(1);
                  ext_in   = 1'b0;
                  st_in    = ST_IDLE;
               end else begin
                  core_start = 1'b1;
                  ext_in     = 1'b1;
                  st_in      = ST_RUN;
               end
            end
         end
         default: begin
            st_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff     <= ST_IDLE;
         chain_ff  <= '0;
         ext_ff    <= 1'b0;
         rem_ff    <= '0;
         ctr_ff    <= CTR_W'(1);
         rvalid_ff <= 1'b0;
         last_ff   <= 1'b0;
      end else begin
         st_ff     <= st_in;
         chain_ff  <= chain_in;
         ext_ff    <= ext_in;
         rem_ff    <= rem_in;
         ctr_ff    <= ctr_in;
         rvalid_ff <= rvalid_in;
         last_ff   <= last_in;
      end
      len_ff   <= len_in;
      rdata_ff <= rdata_in;
      rtake_ff <= rtake_in;
      rlast_ff <= rlast_in;
   end

   assign rsp_tvalid = rvalid_ff;
   // out_hi goes to the low half of the word, out_lo above it.
   assign rsp_tdata  = {3'b000, rtake_ff, rdata_ff[63:0], rdata_ff[127:64]};
   assign rsp_tlast  = rlast_ff;

   // A result word is only ever presented while the sequencer waits for it.
   a_valid_in_out: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (st_ff == ST_OUT))
      else $error("result word presented outside the output state");

   // The round unit only finishes while the sequencer is in the run state.
   a_done_in_run: assert property (@(posedge clock) disable iff (reset)
      core_done |-> (st_ff == ST_RUN))
      else $error("round unit finished outside the run state");

   // After the last word of a run the chain is cleared.
   a_chain_clear: assert property (@(posedge clock) disable iff (reset)
      (rsp_fire && rsp_tlast) |=> (chain_ff == '0 && st_ff == ST_IDLE))
      else $error("chain not cleared after the final word");

   // An accepted message word always starts the round unit.
   a_accept_runs: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> (st_ff == ST_RUN && !req_tready))
      else $error("accepted word did not start an encryption");

endmodule

// File: src/ffp_aes_core.sv
module ffp_aes_core (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [ffp_pkg::KEY_W-1:0]   key,
   input  logic [ffp_pkg::BLOCK_W-1:0] din,
   output logic                        done,
   output logic [ffp_pkg::BLOCK_W-1:0] dout
);
   import ffp_pkg::*;

   // One round per cycle; the key schedule rolls a window of eight words
   // forward by four words after each round.
   logic [BLOCK_W-1:0] state_ff, state_in;
   logic [KEY_W-1:0]   win_ff, win_in;
   logic [7:0]         rcon_ff, rcon_in;
   logic [3:0]         round_ff, round_in;
   logic               busy_ff, busy_in;
   logic               done_ff, done_in;
   logic [31:0]        tmp, n0, n1, n2, n3;
   logic               rot;

   always_comb begin
      rot = round_ff[0];
      tmp = rot ? (sub_word({win_ff[23:0], win_ff[31:24]}) ^ {rcon_ff, 24'h0})
                : sub_word(win_ff[31:0]);
      n0  = win_ff[255:224] ^ tmp;
      n1  = win_ff[223:192] ^ n0;
      n2  = win_ff[191:160] ^ n1;
      n3  = win_ff[159:128] ^ n2;
      state_in = state_ff;
      win_in   = win_ff;
      rcon_in  = rcon_ff;
      round_in = round_ff;
      busy_in  = busy_ff;
      done_in  = 1'b0;
      if (start) begin
         state_in = din ^ key[KEY_W-1 -: BLOCK_W];
         win_in   = key;
         rcon_in  = 8'h01;
         round_in = 4'd1;
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         state_in = aes_round(state_ff, round_ff == 4'(AES_ROUNDS)) ^ win_ff[127:0];
         win_in   = {win_ff[127:0], n0, n1, n2, n3};
         rcon_in  = rot ? xtime(rcon_ff) : rcon_ff;
         round_in = round_ff + 4'd1;
         if (round_ff == 4'(AES_ROUNDS)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         round_ff <= 4'd0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         round_ff <= round_in;
      end
      state_ff <= state_in;
      win_ff   <= win_in;
      rcon_ff  <= rcon_in;
   end

   assign done = done_ff;
   assign dout = state_ff;

endmodule
